[rtl/core/sem_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sobel edge magnitude package
// Shared widths, limits, register indexes, word kinds, sequencer codes and reset geometry.
// ----------------------------------------------------------------------------
package sem_pkg;

  localparam int unsigned MaxWidth   = 2048;
  localparam int unsigned HeightMax  = 4096;
  localparam int unsigned ColW       = $clog2(MaxWidth);     // column index
  localparam int unsigned RowW       = $clog2(HeightMax);    // row index
  localparam int unsigned WidthW     = ColW + 1;             // effective width
  localparam int unsigned HeightW    = RowW + 1;             // effective height
  localparam int unsigned PendW      = ColW + 1;             // up to width+1
  localparam int unsigned PixW       = 8;
  localparam int unsigned GradW      = 12;                   // signed, |g| <= 1020
  localparam int unsigned SqW        = 22;                   // gx^2 + gy^2
  localparam int unsigned MagW       = 11;
  localparam int unsigned CfgAddrW   = 2;
  localparam int unsigned CfgDataW   = 13;
  localparam int unsigned CfgWidthW  = 12;
  localparam int unsigned CfgHeightW = 13;

  localparam logic [CfgAddrW-1:0] RegImageWidth  = 2'd0;
  localparam logic [CfgAddrW-1:0] RegImageHeight = 2'd1;

  localparam logic KindPixel = 1'b0;
  localparam logic KindDrain = 1'b1;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRd   = 3'd1;
  localparam logic [2:0] StGrad = 3'd2;
  localparam logic [2:0] StSqr  = 3'd3;
  localparam logic [2:0] StRoot = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  localparam logic [CfgWidthW-1:0]  WidthReset  = 12'd640;
  localparam logic [CfgHeightW-1:0] HeightReset = 13'd480;

endpackage
`default_nettype wire

[rtl/core/sem_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sem_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2048
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire  [$clog2(DEPTH)-1:0] waddr_i,
  input  wire  [WIDTH-1:0]         wdata_i,
  input  wire  [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

[rtl/core/sobel_edge_magnitude_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sobel edge magnitude unit
// 3x3 Sobel gradient magnitude over a raster pixel stream, two line RAMs.
// ----------------------------------------------------------------------------
// channel   dir  word
// s_axis    in   tdata: pixel[7:0]; tuser: kind (0 pixel, 1 drain)
// m_axis    out  tdata: magnitude[10:0], zero pad to 16; tlast: frame_last
// cfg       in   cfg_we_i / cfg_addr_i / cfg_wdata_i, one register per write
//
// One word at a time. A word with no result passes RAM read, then write
// back. A word with a result passes read, write back, gradient, squares,
// 11 root steps (one result bit per step), output load. An ignored drain
// word never leaves the idle state. The output register lets the next
// word start while a result waits; the block stalls only on loading a second
// result. Reset clears control and the window; the line RAMs are not cleared.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_unit (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire  [7:0]                        s_axis_tdata,   // pixel[7:0]
  input  wire                               s_axis_tuser,   // kind
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  output logic [15:0]                       m_axis_tdata,   // magnitude[10:0], zeros
  output logic                              m_axis_tlast,
  input  wire                               cfg_we_i,
  input  wire  [sem_pkg::CfgAddrW-1:0]      cfg_addr_i,
  input  wire  [sem_pkg::CfgDataW-1:0]      cfg_wdata_i
);

  localparam int unsigned CW = sem_pkg::ColW;
  localparam int unsigned RW = sem_pkg::RowW;
  localparam int unsigned WW = sem_pkg::WidthW;
  localparam int unsigned HW = sem_pkg::HeightW;
  localparam int unsigned PW = sem_pkg::PendW;
  localparam int unsigned GW = sem_pkg::GradW;
  localparam int unsigned SW = sem_pkg::SqW;
  localparam int unsigned MW = sem_pkg::MagW;
  localparam int unsigned XW = sem_pkg::PixW;

  // configuration
  logic [sem_pkg::CfgWidthW-1:0]  width_q;
  logic [sem_pkg::CfgHeightW-1:0] height_q;
  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;

  always_comb begin
    if (width_q < 12'd2) eff_w = WW'(2);
    else if (width_q > sem_pkg::CfgWidthW'(sem_pkg::MaxWidth)) eff_w = WW'(sem_pkg::MaxWidth);
    else eff_w = width_q;
    if (height_q < 13'd2) eff_h = HW'(2);
    else if (height_q > sem_pkg::CfgHeightW'(sem_pkg::HeightMax)) eff_h = HW'(sem_pkg::HeightMax);
    else eff_h = height_q;
  end

  logic cfg_hit;
  assign cfg_hit = cfg_we_i && (cfg_addr_i == sem_pkg::RegImageWidth ||
                                cfg_addr_i == sem_pkg::RegImageHeight);

  // control state
  logic [2:0]    state_q, state_d;
  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic [PW-1:0] pend_q;

  logic [XW-1:0] win_q [3][3];
  logic [XW-1:0] px_q;
  logic [CW-1:0] addr_q;
  logic          kind_q, emit_q, last_q;
  logic          cl_q, cr_q, rt_q, rb_q;
  logic signed [GW-1:0] gx_q, gy_q;
  logic [SW-1:0] sqx_q, sqy_q;
  logic [SW-1:0] rem_q, res_q, bit_q;
  logic          ov_q;
  logic [MW-1:0] mag_q;
  logic          olast_q;

  // RAMs
  logic [XW-1:0] above_rd, two_rd;
  logic [CW-1:0] raddr;
  logic          ram_we;

  assign ram_we = (state_q == sem_pkg::StRd) && (kind_q == sem_pkg::KindPixel);

  sem_ram #(.WIDTH(XW), .DEPTH(sem_pkg::MaxWidth)) u_above (
    .clk_i, .we_i(ram_we), .waddr_i(addr_q), .wdata_i(px_q),
    .raddr_i(raddr), .rdata_o(above_rd)
  );

  sem_ram #(.WIDTH(XW), .DEPTH(sem_pkg::MaxWidth)) u_two (
    .clk_i, .we_i(ram_we), .waddr_i(addr_q), .wdata_i(above_rd),
    .raddr_i(raddr), .rdata_o(two_rd)
  );

  // accept-side decode
  logic          accept, at_start, is_drain, take;
  logic [PW-1:0] pend_base, pend_inc, pend_next;
  logic          emit;
  logic [CW-1:0] c_res, d_addr;
  logic [RW-1:0] r_res;
  logic [HW-1:0] r_tmp, dec;
  logic [CW-1:0] col_next;
  logic [RW-1:0] row_next;

  assign s_axis_tready = (state_q == sem_pkg::StIdle);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign at_start      = (col_q == '0) && (row_q == '0);
  assign is_drain      = (s_axis_tuser == sem_pkg::KindDrain);

  always_comb begin
    pend_base = (at_start && ({1'b0, pend_q} != eff_w + WW'(1))) ? '0 : pend_q;
    pend_inc  = pend_base + PW'(1);
    // pixel path: result lies one row and one column back
    dec   = (col_q == '0) ? HW'(2) : HW'(1);
    r_tmp = ({1'b0, row_q} >= dec) ? ({1'b0, row_q} - dec) : ({1'b0, row_q} + eff_h - dec);
    if (is_drain) begin
      take = at_start && (pend_q != '0);
      emit = take;
      if ({1'b0, pend_q} == eff_w + WW'(1)) begin
        c_res = CW'(eff_w - WW'(1));
        r_res = RW'(eff_h - HW'(2));
      end else begin
        c_res = CW'(eff_w - WW'(pend_q));
        r_res = RW'(eff_h - HW'(1));
      end
      pend_next = pend_q - PW'(1);
    end else begin
      take      = 1'b1;
      emit      = ({1'b0, pend_inc} > eff_w + WW'(1));
      c_res     = (col_q == '0) ? CW'(eff_w - WW'(1)) : col_q - CW'(1);
      r_res     = RW'(r_tmp);
      pend_next = emit ? pend_base : pend_inc;
    end
    d_addr = ({1'b0, c_res} == eff_w - WW'(1)) ? '0 : c_res + CW'(1);
    raddr  = is_drain ? d_addr : col_q;
    if ({1'b0, col_q} + WW'(1) >= eff_w) begin
      col_next = '0;
      row_next = ({1'b0, row_q} + HW'(1) >= eff_h) ? '0 : row_q + RW'(1);
    end else begin
      col_next = col_q + CW'(1);
      row_next = row_q;
    end
  end

  // gradient over the window
  logic signed [GW-1:0] gx, gy, lft, rgt, up, dn, pc;
  logic signed [GW-1:0] wt;
  always_comb begin
    gx = '0;
    gy = '0;
    lft = '0; rgt = '0; up = '0; dn = '0; wt = '0;
    pc = GW'(win_q[1][1]);
    for (int i = 0; i < 3; i++) begin
      wt  = (i == 1) ? GW'(2) : GW'(1);
      lft = cl_q ? pc : GW'(win_q[i][0]);
      rgt = cr_q ? pc : GW'(win_q[i][2]);
      up  = rt_q ? pc : GW'(win_q[0][i]);
      dn  = rb_q ? pc : GW'(win_q[2][i]);
      if (!((i == 0 && rt_q) || (i == 2 && rb_q))) gx = gx + wt * (lft - rgt);
      if (!((i == 0 && cl_q) || (i == 2 && cr_q))) gy = gy + wt * (up - dn);
    end
  end

  // root step; the first step starts from the sum of squares
  logic [SW-1:0] trial, rem_step, res_step, rem_cur;
  always_comb begin
    rem_cur = (bit_q == SW'(1) << (SW - 2)) ? sqx_q + sqy_q : rem_q;
    trial   = res_q + bit_q;
    if (rem_cur >= trial) begin
      rem_step = rem_cur - trial;
      res_step = (res_q >> 1) + bit_q;
    end else begin
      rem_step = rem_cur;
      res_step = res_q >> 1;
    end
  end

  logic out_free;
  assign out_free = !ov_q || m_axis_tready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sem_pkg::StIdle: if (accept && take) state_d = sem_pkg::StRd;
      sem_pkg::StRd:   state_d = emit_q ? sem_pkg::StGrad : sem_pkg::StIdle;
      sem_pkg::StGrad: state_d = sem_pkg::StSqr;
      sem_pkg::StSqr:  state_d = sem_pkg::StRoot;
      sem_pkg::StRoot: if (bit_q[0]) state_d = sem_pkg::StOut;
      sem_pkg::StOut:  if (out_free) state_d = sem_pkg::StIdle;
      default:         state_d = sem_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sem_pkg::StIdle;
      width_q  <= sem_pkg::WidthReset;
      height_q <= sem_pkg::HeightReset;
      col_q    <= '0;
      row_q    <= '0;
      pend_q   <= '0;
      ov_q     <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[i][j] <= '0;
        end
      end
    end else begin
      state_q <= state_d;
      if (cfg_hit) begin
        if (cfg_addr_i == sem_pkg::RegImageWidth) width_q <= cfg_wdata_i[sem_pkg::CfgWidthW-1:0];
        else height_q <= cfg_wdata_i;
        col_q  <= '0;
        row_q  <= '0;
        pend_q <= '0;
      end else if (accept && take) begin
        pend_q <= pend_next;
        if (!is_drain) begin
          col_q <= col_next;
          row_q <= row_next;
        end
      end
      if (state_q == sem_pkg::StRd) begin
        for (int i = 0; i < 3; i++) begin
          win_q[i][0] <= win_q[i][1];
          win_q[i][1] <= win_q[i][2];
        end
        win_q[0][2] <= two_rd;
        win_q[1][2] <= above_rd;
        win_q[2][2] <= (kind_q == sem_pkg::KindDrain) ? '0 : px_q;
      end
      if (state_q == sem_pkg::StOut && out_free) ov_q <= 1'b1;
      else if (m_axis_tready) ov_q <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= s_axis_tuser;
      px_q   <= s_axis_tdata;
      addr_q <= col_q;
      emit_q <= emit;
      cl_q   <= (c_res == '0);
      cr_q   <= ({1'b0, c_res} == eff_w - WW'(1));
      rt_q   <= (r_res == '0);
      rb_q   <= ({1'b0, r_res} == eff_h - HW'(1));
      last_q <= ({1'b0, r_res} == eff_h - HW'(1)) && ({1'b0, c_res} == eff_w - WW'(1));
    end
    if (state_q == sem_pkg::StGrad) begin
      gx_q <= gx;
      gy_q <= gy;
    end
    if (state_q == sem_pkg::StSqr) begin
      sqx_q <= SW'(gx_q) * SW'(gx_q);
      sqy_q <= SW'(gy_q) * SW'(gy_q);
      res_q <= '0;
      bit_q <= SW'(1) << (SW - 2);
    end
    if (state_q == sem_pkg::StRoot) begin
      rem_q <= rem_step;
      res_q <= res_step;
      bit_q <= bit_q >> 2;
    end
    if (state_q == sem_pkg::StOut && out_free) begin
      mag_q   <= res_q[MW-1:0];
      olast_q <= last_q;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {{(16 - MW){1'b0}}, mag_q};
  assign m_axis_tlast  = olast_q;

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, pend_q} <= eff_w + WW'(1))
    else $error("pending count above width+1");
  a_root_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sem_pkg::StRoot |-> $onehot(bit_q))
    else $error("root step bit not one-hot");
  a_no_emit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sem_pkg::StRd && !emit_q |=> state_q == sem_pkg::StIdle)
    else $error("word without result did not retire");

endmodule
`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel edge magnitude unit testbench
// Streams pixel and drain words through the unit under several frame
// geometries, predicts each gradient magnitude and frame_last flag, and
// compares every output word with the oldest predicted result.
// ----------------------------------------------------------------------------
module tb;

  typedef struct packed {
    logic [sem_pkg::MagW-1:0] magnitude;
    logic                     frame_last;
  } edge_result_t;

  localparam int unsigned StallLimit = 4000;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  wire                          s_axis_tready;
  logic [7:0]                   s_axis_tdata = '0;
  logic                         s_axis_tuser = sem_pkg::KindPixel;
  wire                          m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  wire  [15:0]                  m_axis_tdata;
  wire                          m_axis_tlast;
  logic                         cfg_we_i = 1'b0;
  logic [sem_pkg::CfgAddrW-1:0] cfg_addr_i = sem_pkg::RegImageWidth;
  logic [sem_pkg::CfgDataW-1:0] cfg_wdata_i = '0;

  sobel_edge_magnitude_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // predictor state
  logic [7:0]                     line_above [sem_pkg::MaxWidth];
  logic [7:0]                     line_two_above [sem_pkg::MaxWidth];
  int                             win [3][3];
  int unsigned                    col_pos, row_pos, pending;
  logic [sem_pkg::CfgWidthW-1:0]  width_reg = sem_pkg::WidthReset;
  logic [sem_pkg::CfgHeightW-1:0] height_reg = sem_pkg::HeightReset;
  edge_result_t                   expected_q [$];

  int  errors = 0;
  int  sent_items = 0;
  bit  quiet = 1'b0;
  bit  in_gap_mode = 1'b0;
  int  stall_left = 0;
  int  idle_cycles = 0;

  function automatic int unsigned frame_width();
    if (width_reg < 2) return 2;
    if (width_reg > sem_pkg::MaxWidth) return sem_pkg::MaxWidth;
    return width_reg;
  endfunction

  function automatic int unsigned frame_height();
    if (height_reg < 2) return 2;
    if (height_reg > sem_pkg::HeightMax) return sem_pkg::HeightMax;
    return height_reg;
  endfunction

  function automatic int unsigned isqrt(int unsigned v);
    int unsigned r;
    r = 0;
    for (int b = 10; b >= 0; b--) begin
      if ((r | (1 << b)) * (r | (1 << b)) <= v) r |= (1 << b);
    end
    return r;
  endfunction

  function automatic void shift_in(int top, int mid, int bot);
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = bot;
  endfunction

  // magnitude for frame position m, window centred on that pixel
  function automatic void push_gradient(int unsigned m, int unsigned w, int unsigned h);
    int unsigned  r, c;
    int           p, gx, gy, wt, lft, rgt, up, dn;
    edge_result_t res;
    r = m / w;
    c = m % w;
    p = win[1][1];
    gx = 0;
    gy = 0;
    for (int i = 0; i < 3; i++) begin
      wt = (i == 1) ? 2 : 1;
      if (!((i == 0 && r == 0) || (i == 2 && r == h - 1))) begin
        lft = (c == 0) ? p : win[i][0];
        rgt = (c == w - 1) ? p : win[i][2];
        gx += wt * (lft - rgt);
      end
      if (!((i == 0 && c == 0) || (i == 2 && c == w - 1))) begin
        up = (r == 0) ? p : win[0][i];
        dn = (r == h - 1) ? p : win[2][i];
        gy += wt * (up - dn);
      end
    end
    res.magnitude = sem_pkg::MagW'(isqrt(gx * gx + gy * gy));
    res.frame_last = (m == w * h - 1);
    expected_q.push_back(res);
  endfunction

  function automatic void predict_word(logic kind, logic [7:0] px);
    int unsigned w, h, fsize, n, m, d, c;
    int          a2, a1;
    bit          at_start;
    w = frame_width();
    h = frame_height();
    fsize = w * h;
    at_start = (col_pos == 0 && row_pos == 0);
    if (kind == sem_pkg::KindDrain) begin
      if (!at_start || pending == 0) return;
      m = fsize - pending;
      d = (m % w + 1) % w;
      shift_in(line_two_above[d], line_above[d], 0);
      push_gradient(m, w, h);
      pending--;
    end else begin
      c = col_pos;
      n = row_pos * w + col_pos;
      if (at_start && pending != w + 1) pending = 0;
      a2 = line_two_above[c];
      a1 = line_above[c];
      line_two_above[c] = a1;
      line_above[c] = px;
      shift_in(a2, a1, px);
      pending++;
      col_pos++;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
        if (row_pos >= h) row_pos = 0;
      end
      if (pending > w + 1) begin
        push_gradient((n + fsize - (w + 1)) % fsize, w, h);
        pending--;
      end
    end
  endfunction

  task automatic send_word(logic kind, logic [7:0] px);
    if (!quiet && (in_gap_mode || $urandom_range(0, 7) == 0)) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      in_gap_mode = ($urandom_range(0, 3) == 0);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= px;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_word(kind, px);
    sent_items++;
  endtask

  task automatic send_pixel(logic [7:0] px);
    send_word(sem_pkg::KindPixel, px);
  endtask

  task automatic send_drain(int count);
    repeat (count) send_word(sem_pkg::KindDrain, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_random_pixels(int count);
    repeat (count) send_pixel(8'($urandom_range(0, 255)));
  endtask

  // waits out all results plus the tail of a word that makes none
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [sem_pkg::CfgAddrW-1:0] addr, int unsigned value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= sem_pkg::CfgDataW'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (addr == sem_pkg::RegImageWidth) width_reg = sem_pkg::CfgWidthW'(value);
    else height_reg = sem_pkg::CfgHeightW'(value);
    col_pos = 0;
    row_pos = 0;
    pending = 0;
  endtask

  task automatic set_geometry(int unsigned w, int unsigned h);
    write_reg(sem_pkg::RegImageWidth, w);
    write_reg(sem_pkg::RegImageHeight, h);
  endtask

  // reset geometry 640x480; drains mid-frame are ignored
  task automatic test_reset_geometry();
    send_random_pixels(645);
    send_drain(3);
    send_random_pixels(5);
  endtask

  task automatic test_directed();
    // width of zero and height of one clamp to 2
    set_geometry(0, 1);
    send_pixel(8'd0);
    send_pixel(8'd255);
    send_pixel(8'd255);
    send_pixel(8'd0);
    send_drain(3);
    send_drain(1);          // nothing pending
    set_geometry(4, 3);
    for (int i = 0; i < 12; i++) send_pixel((i % 3 == 0) ? 8'd255 : 8'd0);
    send_drain(2);          // partly drained, next frame drops the rest
    for (int i = 0; i < 12; i++) send_pixel(i[0] ? 8'd255 : 8'd0);
    // flows straight into a third frame
    for (int i = 0; i < 12; i++) send_pixel(8'hAA ^ i[7:0]);
    send_drain(5);
  endtask

  task automatic test_extremes();
    set_geometry(2, 8191);  // height clamps to the maximum
    send_random_pixels(24);
    set_geometry(2, sem_pkg::HeightMax);
    send_random_pixels(10);
  endtask

  task automatic test_random_frames();
    int unsigned w, h, frames, start_count;
    start_count = sent_items;
    while (sent_items - start_count < 680) begin
      if (sent_items - start_count > 540) quiet = 1'b1;
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40) : $urandom_range(0, 16);
      h = $urandom_range(0, 6);
      if ($urandom_range(0, 1) == 0) begin
        write_reg(sem_pkg::RegImageWidth, w);
        write_reg(sem_pkg::RegImageHeight, h);
      end else begin
        write_reg(sem_pkg::RegImageHeight, h);
        write_reg(sem_pkg::RegImageWidth, w);
      end
      w = frame_width();
      h = frame_height();
      frames = $urandom_range(1, 3);
      for (int f = 0; f < frames; f++) begin
        for (int i = 0; i < w * h; i++) begin
          if ($urandom_range(0, 24) == 0) send_drain(1);  // taken only at frame start with results pending
          send_pixel(8'($urandom_range(0, 255)));
        end
        case ($urandom_range(0, 3))
          0: ;                                        // flow on
          1: send_drain($urandom_range(1, w));        // partial
          default: send_drain(w + 1 + $urandom_range(0, 1));
        endcase
      end
      if ($urandom_range(0, 3) == 0) send_random_pixels($urandom_range(1, w * h));
    end
  endtask

  // output side: check, stall, watchdog
  always @(posedge clk_i) begin
    edge_result_t exp_res;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected word: magnitude %0d", m_axis_tdata[sem_pkg::MagW-1:0]);
          errors++;
        end else begin
          exp_res = expected_q.pop_front();
          if (m_axis_tdata[sem_pkg::MagW-1:0] !== exp_res.magnitude) begin
            $error("magnitude: expected %0d, actual %0d", exp_res.magnitude,
                   m_axis_tdata[sem_pkg::MagW-1:0]);
            errors++;
          end
          if (m_axis_tlast !== exp_res.frame_last) begin
            $error("frame_last: expected %0d, actual %0d", exp_res.frame_last,
                   m_axis_tlast);
            errors++;
          end
        end
      end
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= StallLimit) begin
          $display("status: fail");
          $finish;
        end
      end
    end
    if (quiet) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 12) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  initial begin
    foreach (line_above[i]) begin
      line_above[i] = '0;
      line_two_above[i] = '0;
    end
    foreach (win[i, j]) win[i][j] = 0;
    col_pos = 0;
    row_pos = 0;
    pending = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_geometry();
    test_directed();
    test_extremes();
    test_random_frames();
    wait_idle();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
